// ----- src/hsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB package
// Constants and sextant codes shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int unsigned IN_W    = 32;
    localparam int unsigned LEVEL_W = 8;

    // Hue folding: byte weights of a 32-bit word taken modulo 360.
    localparam logic [16:0] HUE_W2   = 17'd16;   // 2^16 mod 360
    localparam logic [16:0] HUE_W3   = 17'd136;  // 2^24 mod 360
    localparam logic [16:0] HUE_NEG  = 17'd104;  // -(2^32) mod 360
    localparam logic [16:0] HUE_CIRCLE = 17'd360;

    // floor(x / 360) for x < 2^17: (x * 2912) >> 20, low by at most one.
    localparam logic [11:0] HUE_RECIP = 12'd2912;
    localparam int unsigned HUE_SHIFT = 20;

    // floor(h / 60) for h < 360: (h * 1093) >> 16, exact.
    localparam logic [10:0] SPAN_RECIP = 11'd1093;
    localparam int unsigned SPAN_SHIFT = 16;
    localparam logic [8:0]  SEXTANT_SPAN = 9'd60;

    localparam logic [7:0]  LEVEL_MAX  = 8'd255;
    localparam logic [13:0] SPAN_SCALE = 14'd15300;

    // floor(p / 255) for p < 2^16: (p * 32897) >> 23, exact.
    localparam logic [15:0] M_RECIP = 16'd32897;
    localparam int unsigned M_SHIFT = 23;

    // floor(p / 15300) for p <= 3901500: (p * 17965877) >> 38, exact.
    localparam logic [24:0] NK_RECIP = 25'd17965877;
    localparam int unsigned NK_SHIFT = 38;

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } t_sextant;

endpackage

// ----- src/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Ten-stage pipeline: hue folded modulo 360, sextant split, three levels by
// exact reciprocal division, then placed into red, green and blue.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | start, busy            | i_hue, i_saturation, i_brightness
//   result   | o_valid (strobe)       | o_red, o_green, o_blue
//
// One transaction per cycle.
// Stages: hue fold 1, reduction modulo 360 3, sextant and offset 2, level
// factors 1, level multiply 1, reciprocal multiply 1, placement 1.
// busy is always low; valid bits move with the data every cycle.
// Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hsv_pkg::IN_W-1:0]       i_hue,
    input  logic signed [hsv_pkg::IN_W-1:0]       i_saturation,
    input  logic signed [hsv_pkg::IN_W-1:0]       i_brightness,
    output logic                                  o_valid,
    output logic        [hsv_pkg::LEVEL_W-1:0]    o_red,
    output logic        [hsv_pkg::LEVEL_W-1:0]    o_green,
    output logic        [hsv_pkg::LEVEL_W-1:0]    o_blue
);

    localparam int unsigned STAGES = 10;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;

    // stage 1: clamp, fold hue bytes
    logic [16:0] r_s1_sum,  n_s1_sum;
    logic [7:0]  r_s1_s,    n_s1_s;
    logic [7:0]  r_s1_v,    n_s1_v;
    // stage 2: quotient estimate
    logic [16:0] r_s2_sum;
    logic [8:0]  r_s2_q,    n_s2_q;
    logic [7:0]  r_s2_s,    r_s2_v;
    // stage 3: remainder
    logic [9:0]  r_s3_rem,  n_s3_rem;
    logic [7:0]  r_s3_s,    r_s3_v;
    // stage 4: corrected hue
    logic [8:0]  r_s4_hh,   n_s4_hh;
    logic [7:0]  r_s4_s,    r_s4_v;
    // stage 5: sextant
    logic [8:0]  r_s5_hh;
    logic [2:0]  r_s5_sec,  n_s5_sec;
    logic [7:0]  r_s5_s,    r_s5_v;
    // stage 6: offset in sextant
    logic [5:0]  r_s6_r,    n_s6_r;
    logic [2:0]  r_s6_sec;
    logic [7:0]  r_s6_s,    r_s6_v;
    // stage 7: level factors
    logic [7:0]  r_s7_tm,   n_s7_tm;
    logic [13:0] r_s7_tn,   n_s7_tn;
    logic [13:0] r_s7_tk,   n_s7_tk;
    logic [2:0]  r_s7_sec;
    logic [7:0]  r_s7_v;
    // stage 8: scaled products
    logic [15:0] r_s8_pm,   n_s8_pm;
    logic [21:0] r_s8_pn,   n_s8_pn;
    logic [21:0] r_s8_pk,   n_s8_pk;
    logic [2:0]  r_s8_sec;
    logic [7:0]  r_s8_v;
    // stage 9: levels
    logic [7:0]  r_s9_m,    n_s9_m;
    logic [7:0]  r_s9_n,    n_s9_n;
    logic [7:0]  r_s9_k,    n_s9_k;
    logic [2:0]  r_s9_sec;
    logic [7:0]  r_s9_v;
    // stage 10: output
    logic [7:0]  r_red,   n_red;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_blue,  n_blue;

    logic [28:0] w_qprod;
    logic [16:0] w_rem_full;
    logic [19:0] w_secprod;
    logic [8:0]  w_roff;
    logic [13:0] w_rs;
    logic [13:0] w_rks;
    logic [5:0]  w_rk;
    logic [31:0] w_mprod;
    logic [46:0] w_nprod;
    logic [46:0] w_kprod;

    assign busy = 1'b0;
    assign n_vld = {r_vld[STAGES-2:0], start};

    // stage 1
    assign n_s1_sum = 17'(i_hue[7:0])
                    + {1'b0, i_hue[15:8], 8'd0}
                    + 17'(i_hue[23:16]) * hsv_pkg::HUE_W2
                    + 17'(i_hue[31:24]) * hsv_pkg::HUE_W3
                    + (i_hue[31] ? hsv_pkg::HUE_NEG : 17'd0);
    assign n_s1_s = i_saturation[31] ? 8'd0 :
                    (|i_saturation[30:8]) ? hsv_pkg::LEVEL_MAX : i_saturation[7:0];
    assign n_s1_v = i_brightness[31] ? 8'd0 :
                    (|i_brightness[30:8]) ? hsv_pkg::LEVEL_MAX : i_brightness[7:0];

    // stage 2
    assign w_qprod = 29'(r_s1_sum) * 29'(hsv_pkg::HUE_RECIP);
    assign n_s2_q  = w_qprod[hsv_pkg::HUE_SHIFT+8:hsv_pkg::HUE_SHIFT];

    // stage 3
    assign w_rem_full = r_s2_sum - 17'(r_s2_q) * hsv_pkg::HUE_CIRCLE;
    assign n_s3_rem   = w_rem_full[9:0];

    // stage 4
    assign n_s4_hh = (r_s3_rem >= 10'(hsv_pkg::HUE_CIRCLE))
                   ? 9'(r_s3_rem - 10'(hsv_pkg::HUE_CIRCLE)) : r_s3_rem[8:0];

    // stage 5
    assign w_secprod = 20'(r_s4_hh) * 20'(hsv_pkg::SPAN_RECIP);
    assign n_s5_sec  = w_secprod[hsv_pkg::SPAN_SHIFT+2:hsv_pkg::SPAN_SHIFT];

    // stage 6
    assign w_roff = r_s5_hh - 9'(r_s5_sec) * hsv_pkg::SEXTANT_SPAN;
    assign n_s6_r = w_roff[5:0];

    // stage 7
    assign w_rk    = 6'(hsv_pkg::SEXTANT_SPAN) - r_s6_r;
    assign w_rs    = 14'(r_s6_r) * 14'(r_s6_s);
    assign w_rks   = 14'(w_rk) * 14'(r_s6_s);
    assign n_s7_tm = hsv_pkg::LEVEL_MAX - r_s6_s;
    assign n_s7_tn = hsv_pkg::SPAN_SCALE - w_rs;
    assign n_s7_tk = hsv_pkg::SPAN_SCALE - w_rks;

    // stage 8
    assign n_s8_pm = 16'(r_s7_v) * 16'(r_s7_tm);
    assign n_s8_pn = 22'(r_s7_v) * 22'(r_s7_tn);
    assign n_s8_pk = 22'(r_s7_v) * 22'(r_s7_tk);

    // stage 9
    assign w_mprod = 32'(r_s8_pm) * 32'(hsv_pkg::M_RECIP);
    assign w_nprod = 47'(r_s8_pn) * 47'(hsv_pkg::NK_RECIP);
    assign w_kprod = 47'(r_s8_pk) * 47'(hsv_pkg::NK_RECIP);
    assign n_s9_m  = w_mprod[hsv_pkg::M_SHIFT+7:hsv_pkg::M_SHIFT];
    assign n_s9_n  = w_nprod[hsv_pkg::NK_SHIFT+7:hsv_pkg::NK_SHIFT];
    assign n_s9_k  = w_kprod[hsv_pkg::NK_SHIFT+7:hsv_pkg::NK_SHIFT];

    // stage 10: place levels by sextant
    always_comb begin
        case (hsv_pkg::t_sextant'(r_s9_sec))
            hsv_pkg::SEXT_0: begin
                n_red = r_s9_v; n_green = r_s9_k; n_blue = r_s9_m;
            end
            hsv_pkg::SEXT_1: begin
                n_red = r_s9_n; n_green = r_s9_v; n_blue = r_s9_m;
            end
            hsv_pkg::SEXT_2: begin
                n_red = r_s9_m; n_green = r_s9_v; n_blue = r_s9_k;
            end
            hsv_pkg::SEXT_3: begin
                n_red = r_s9_m; n_green = r_s9_n; n_blue = r_s9_v;
            end
            hsv_pkg::SEXT_4: begin
                n_red = r_s9_k; n_green = r_s9_m; n_blue = r_s9_v;
            end
            default: begin
                n_red = r_s9_v; n_green = r_s9_m; n_blue = r_s9_n;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sum <= n_s1_sum;
        r_s1_s   <= n_s1_s;
        r_s1_v   <= n_s1_v;

        r_s2_sum <= r_s1_sum;
        r_s2_q   <= n_s2_q;
        r_s2_s   <= r_s1_s;
        r_s2_v   <= r_s1_v;

        r_s3_rem <= n_s3_rem;
        r_s3_s   <= r_s2_s;
        r_s3_v   <= r_s2_v;

        r_s4_hh  <= n_s4_hh;
        r_s4_s   <= r_s3_s;
        r_s4_v   <= r_s3_v;

        r_s5_hh  <= r_s4_hh;
        r_s5_sec <= n_s5_sec;
        r_s5_s   <= r_s4_s;
        r_s5_v   <= r_s4_v;

        r_s6_r   <= n_s6_r;
        r_s6_sec <= r_s5_sec;
        r_s6_s   <= r_s5_s;
        r_s6_v   <= r_s5_v;

        r_s7_tm  <= n_s7_tm;
        r_s7_tn  <= n_s7_tn;
        r_s7_tk  <= n_s7_tk;
        r_s7_sec <= r_s6_sec;
        r_s7_v   <= r_s6_v;

        r_s8_pm  <= n_s8_pm;
        r_s8_pn  <= n_s8_pn;
        r_s8_pk  <= n_s8_pk;
        r_s8_sec <= r_s7_sec;
        r_s8_v   <= r_s7_v;

        r_s9_m   <= n_s9_m;
        r_s9_n   <= n_s9_n;
        r_s9_k   <= n_s9_k;
        r_s9_sec <= r_s8_sec;
        r_s9_v   <= r_s8_v;

        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ----- dv/hsv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB checker
// Watches the command and result channels of the converter, predicts the
// red, green and blue levels of every accepted transaction and compares each
// strobed result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hsv_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [hsv_pkg::IN_W-1:0]       i_hue,
    input  logic signed [hsv_pkg::IN_W-1:0]       i_saturation,
    input  logic signed [hsv_pkg::IN_W-1:0]       i_brightness,
    input  logic                                  o_valid,
    input  logic        [hsv_pkg::LEVEL_W-1:0]    o_red,
    input  logic        [hsv_pkg::LEVEL_W-1:0]    o_green,
    input  logic        [hsv_pkg::LEVEL_W-1:0]    o_blue,
    output int                                    o_pending,
    output int                                    o_fail_count
);

    localparam int DEG_CIRCLE  = 360;
    localparam int DEG_SPAN    = 60;
    localparam int FULL_LEVEL  = 255;
    localparam int LEVEL_SCALE = DEG_SPAN * FULL_LEVEL;
    localparam int EXP_DEPTH   = 32;

    typedef struct packed {
        logic [hsv_pkg::LEVEL_W-1:0] red;
        logic [hsv_pkg::LEVEL_W-1:0] green;
        logic [hsv_pkg::LEVEL_W-1:0] blue;
    } t_rgb;

    t_rgb       exp_mem [EXP_DEPTH];
    logic [4:0] exp_wr_ptr;
    logic [4:0] exp_rd_ptr;
    int         exp_count;

    function automatic int clamp_level(input logic signed [hsv_pkg::IN_W-1:0] x);
        if (x < 0)
            return 0;
        if (x > FULL_LEVEL)
            return FULL_LEVEL;
        return int'(x);
    endfunction

    function automatic t_rgb hsv_to_rgb(input logic signed [hsv_pkg::IN_W-1:0] hue,
                                        input logic signed [hsv_pkg::IN_W-1:0] sat,
                                        input logic signed [hsv_pkg::IN_W-1:0] val);
        int h;
        int s;
        int v;
        int r;
        int m;
        int n;
        int k;
        hsv_pkg::t_sextant sext;
        t_rgb rgb;
        h = hue % DEG_CIRCLE;
        if (h < 0)
            h += DEG_CIRCLE;
        s = clamp_level(sat);
        v = clamp_level(val);
        if (s == 0) begin
            rgb = {8'(v), 8'(v), 8'(v)};
        end else begin
            sext = hsv_pkg::t_sextant'(h / DEG_SPAN);
            r = h % DEG_SPAN;
            m = (v * (FULL_LEVEL - s)) / FULL_LEVEL;
            n = (v * (LEVEL_SCALE - r * s)) / LEVEL_SCALE;
            k = (v * (LEVEL_SCALE - (DEG_SPAN - r) * s)) / LEVEL_SCALE;
            case (sext)
                hsv_pkg::SEXT_0: rgb = {8'(v), 8'(k), 8'(m)};
                hsv_pkg::SEXT_1: rgb = {8'(n), 8'(v), 8'(m)};
                hsv_pkg::SEXT_2: rgb = {8'(m), 8'(v), 8'(k)};
                hsv_pkg::SEXT_3: rgb = {8'(m), 8'(n), 8'(v)};
                hsv_pkg::SEXT_4: rgb = {8'(k), 8'(m), 8'(v)};
                default:         rgb = {8'(v), 8'(m), 8'(n)};
            endcase
        end
        return rgb;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        exp_wr_ptr   = '0;
        exp_rd_ptr   = '0;
        exp_count    = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_rgb want;
        if (!i_rst_n) begin
            o_pending <= 0;
        end else begin
            if (start && !busy) begin
                if (exp_count == EXP_DEPTH) begin
                    report_mismatch("too many transactions in flight");
                end else begin
                    exp_mem[exp_wr_ptr] = hsv_to_rgb(i_hue, i_saturation, i_brightness);
                    exp_wr_ptr = exp_wr_ptr + 5'd1;
                    exp_count++;
                end
            end
            if (o_valid === 1'b1) begin
                if (exp_count == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no transaction pending",
                                              o_red, o_green, o_blue));
                end else begin
                    want = exp_mem[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 5'd1;
                    exp_count--;
                    if (o_red !== want.red)
                        report_mismatch($sformatf("red got %0d expected %0d",
                                                  o_red, want.red));
                    if (o_green !== want.green)
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  o_green, want.green));
                    if (o_blue !== want.blue)
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  o_blue, want.blue));
                end
            end
            o_pending <= exp_count;
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner colors, then random hue, saturation and value
// transactions under three sender idle profiles, and takes the verdict from
// the checker that predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS  = 610;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;

    localparam logic signed [hsv_pkg::IN_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [hsv_pkg::IN_W-1:0] INT_MAX = 32'sh7fff_ffff;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic signed [hsv_pkg::IN_W-1:0]      i_hue = '0;
    logic signed [hsv_pkg::IN_W-1:0]      i_saturation = '0;
    logic signed [hsv_pkg::IN_W-1:0]      i_brightness = '0;
    logic                                 busy;
    logic                                 o_valid;
    logic        [hsv_pkg::LEVEL_W-1:0]   o_red;
    logic        [hsv_pkg::LEVEL_W-1:0]   o_green;
    logic        [hsv_pkg::LEVEL_W-1:0]   o_blue;

    int pending_cnt;
    int fail_cnt;
    int idle_cycles = 0;
    int idle_pct = 0;

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    hsv_to_rgb_converter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    hsv_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_pending    (pending_cnt),
        .o_fail_count (fail_cnt)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [hsv_pkg::IN_W-1:0] rand_hue();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 359);
            4, 5:       return 60 * int'($urandom_range(0, 6)) - int'($urandom_range(0, 1));
            6:          return -int'($urandom_range(1, 2000));
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic signed [hsv_pkg::IN_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 255);
            6:                return $urandom_range(0, 1) ? 255 : 0;
            7:                return -int'($urandom_range(1, 1000));
            8:                return $urandom_range(256, 100000);
            default:          return $urandom;
        endcase
    endfunction

    task automatic send_color(input logic signed [hsv_pkg::IN_W-1:0] hue,
                              input logic signed [hsv_pkg::IN_W-1:0] sat,
                              input logic signed [hsv_pkg::IN_W-1:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int pct);
        idle_pct = pct;
        repeat (PHASE_ITEMS)
            send_color(rand_hue(), rand_level(), rand_level());
        drain_results();
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // grey, clamping and sextant edges
        send_color(0, 0, 0);
        send_color(123, 0, 200);
        send_color(0, 255, 255);
        send_color(59, 255, 255);
        send_color(60, 255, 255);
        send_color(119, 255, 200);
        send_color(120, 255, 255);
        send_color(180, 255, 255);
        send_color(240, 255, 128);
        send_color(300, 255, 255);
        send_color(359, 255, 255);
        send_color(360, 255, 255);
        send_color(-1, 255, 255);
        send_color(-360, 128, 255);
        send_color(-361, 200, 100);
        send_color(INT_MIN, 255, 255);
        send_color(INT_MAX, 255, 255);
        send_color(30, 256, 255);
        send_color(90, -1, 77);
        send_color(150, INT_MIN, INT_MAX);
        send_color(210, INT_MAX, INT_MIN);
        send_color(270, 1, 255);
        send_color(330, 128, -5);
        send_color(45, 255, 1);
        drain_results();

        run_random_phase(27);
        run_random_phase(74);
        run_random_phase(0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/hsv_pkg.sv
src/hsv_to_rgb_converter.sv
dv/hsv_checker.sv
dv/tb.sv
